@@ hw/rtl/ignition_retry_sequencer_defines.svh @@
// Assertion macros for the ignition retry sequencer.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef IGNITION_RETRY_SEQUENCER_DEFINES_SVH
`define IGNITION_RETRY_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked while out of reset.
`define IRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked at every edge, reset included.
`define IRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IRS_ASSERT(lbl, prop, msg)
`define IRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/irs_pkg.sv @@
`default_nettype none

package irs_pkg;

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int TEMP_W   = 15;
  localparam int PHASE_W  = 3;
  localparam int BURN_W   = 22;
  localparam int CNT_W    = 16;
  localparam int SECS_W   = 12;
  localparam int RISE_W   = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int TICKS_PER_SECOND = 1000;
  localparam logic [BURN_W-1:0] BURN_MAX = {BURN_W{1'b1}};

  // Commands carried by an input transaction.
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

  // Sequencer phases.
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SET   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PULSE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_OK    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_FAIL  = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BURN_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RISE      = 2'd3;

  typedef struct packed {
    logic [SECS_W-1:0] burn_time_s;
    logic [CNT_W-1:0]  pulse_width_ms;
    logic [CNT_W-1:0]  repeat_interval_ms;
    logic [RISE_W-1:0] rise_threshold;
  } irs_cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]       phase;
    logic                     pending;
    logic signed [TEMP_W-1:0] start_temp;
    logic [BURN_W-1:0]        burn;
    logic [CNT_W-1:0]         pulse;
    logic                     coil;
  } irs_state_t;

  // Burn timeout in ticks, saturating at the counter's maximum.
  function automatic logic [BURN_W-1:0] burn_load(input logic [SECS_W-1:0] secs);
    logic [BURN_W:0] prod;
    prod = (BURN_W+1)'(secs) * (BURN_W+1)'(TICKS_PER_SECOND);
    return (prod > (BURN_W+1)'(BURN_MAX)) ? BURN_MAX : prod[BURN_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/irs_step.sv @@
`default_nettype none

// One sequencer step: the next state for one command and temperature.
module irs_step
  import irs_pkg::*;
(
  input  irs_state_t               cur,
  input  irs_cfg_t                 cfg,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [TEMP_W-1:0] temp,
  output irs_state_t               nxt
);

  logic [BURN_W-1:0]   burn_dec;
  logic [CNT_W-1:0]    pulse_dec;
  logic signed [16:0]  rise;
  logic signed [16:0]  thresh;
  logic                risen;

  // Both counters drop by one on a tick and stop at zero.
  assign burn_dec  = (cur.burn  != '0) ? cur.burn  - 1'b1 : '0;
  assign pulse_dec = (cur.pulse != '0) ? cur.pulse - 1'b1 : '0;

  // Temperature rise since start, compared as exact signed integers.
  assign rise   = 17'(temp) - 17'(cur.start_temp);
  assign thresh = $signed({3'b000, cfg.rise_threshold});
  assign risen  = (rise >= thresh);

  always_comb begin
    nxt = cur;
    case (cmd)
      CMD_TICK: begin
        nxt.burn  = burn_dec;
        nxt.pulse = pulse_dec;
        case (cur.phase)
          PH_SET: begin
            nxt.coil  = 1'b1;
            nxt.pulse = cfg.pulse_width_ms;
            nxt.phase = PH_PULSE;
          end
          PH_PULSE: begin
            if (pulse_dec == '0) begin
              nxt.coil  = 1'b0;
              nxt.pulse = cfg.repeat_interval_ms;
              nxt.phase = PH_WAIT;
            end
          end
          PH_WAIT: begin
            if (risen) begin
              nxt.phase = PH_OK;
            end else if (burn_dec == '0) begin
              nxt.phase = PH_FAIL;
            end else if (pulse_dec == '0) begin
              nxt.phase = PH_SET;
            end
          end
          PH_OK, PH_FAIL: begin
            nxt.phase = cur.phase;
          end
          default: begin
            // Idle, and the unused codes, which act as idle.
            if (cur.pending) begin
              nxt.pending    = 1'b0;
              nxt.burn       = burn_load(cfg.burn_time_s);
              nxt.start_temp = temp;
              nxt.coil       = 1'b1;
              nxt.pulse      = cfg.pulse_width_ms;
              nxt.phase      = PH_PULSE;
            end
          end
        endcase
      end
      CMD_START: begin
        nxt.pending = 1'b1;
      end
      CMD_RESET: begin
        nxt.coil  = 1'b0;
        nxt.phase = PH_IDLE;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/ignition_retry_sequencer.sv @@
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_cmd[1:0], in_temperature[14:0] signed
// out_      output     out_valid/out_ready  out_coil_on, out_phase[2:0]
// cfg_      input      cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[15:0]
//
// One transaction per cycle sustained while out_ready is high; a transaction passes the input
// register, then the sequencer state, which doubles as the result register.
// The step logic between the two (counter decrement, 12x10 burn product, 17-bit
// compare) sets the clock period.
// rst_n is synchronous and active low: state clears and registers take defaults.
// A stalled result holds; the input register then keeps one transaction waiting.
// cfg_ready is always high.
`default_nettype none
`include "ignition_retry_sequencer_defines.svh"

module ignition_retry_sequencer
  import irs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [CMD_W-1:0]         in_cmd,
  input  wire logic signed [TEMP_W-1:0] in_temperature,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_coil_on,
  output logic [PHASE_W-1:0]            out_phase,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DAT_W-1:0]     cfg_data
);

  irs_cfg_t                 cfg_r;
  logic                     s1_valid_r;
  logic [CMD_W-1:0]         s1_cmd_r;
  logic signed [TEMP_W-1:0] s1_temp_r;
  irs_state_t               state_r;
  irs_state_t               state_nxt;
  logic                     out_valid_r;
  logic                     advance;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.burn_time_s        <= SECS_W'(60);
      cfg_r.pulse_width_ms     <= CNT_W'(1000);
      cfg_r.repeat_interval_ms <= CNT_W'(10000);
      cfg_r.rise_threshold     <= RISE_W'(200);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BURN_TIME: cfg_r.burn_time_s        <= cfg_data[SECS_W-1:0];
        REG_PULSE:     cfg_r.pulse_width_ms     <= cfg_data;
        REG_REPEAT:    cfg_r.repeat_interval_ms <= cfg_data;
        REG_RISE:      cfg_r.rise_threshold     <= cfg_data[RISE_W-1:0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  // The held transaction steps the state once the result slot is free.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r  <= in_cmd;
      s1_temp_r <= in_temperature;
    end
  end

  irs_step u_step (
    .cur  (state_r),
    .cfg  (cfg_r),
    .cmd  (s1_cmd_r),
    .temp (s1_temp_r),
    .nxt  (state_nxt)
  );

  // Sequencer state; its phase and coil bits are the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_coil_on = state_r.coil;
  assign out_phase   = state_r.phase;

  // The coil is driven exactly while a pulse is running.
  `IRS_ASSERT(a_coil_pulse, state_r.coil == (state_r.phase == PH_PULSE), "coil and phase disagree")
  // A success outcome is left only for idle.
  `IRS_ASSERT(a_ok_hold, state_r.phase == PH_OK |=> state_r.phase == PH_OK || state_r.phase == PH_IDLE, "success left wrongly")
  // The pending start is consumed only by starting a pulse.
  `IRS_ASSERT(a_pend_use, $fell(state_r.pending) |-> state_r.phase == PH_PULSE && state_r.coil, "start lost")
  // Input is refused only when both stages are full and the result stalls.
  `IRS_ASSERT(a_ready, !in_ready |-> s1_valid_r && out_valid_r && !out_ready, "needless stall")
  // Reset leaves no result pending.
  `IRS_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_valid_r && !s1_valid_r, "valid after reset")

endmodule

`default_nettype wire

@@ tb/irs_tb_pkg.sv @@
package irs_tb_pkg;
  import irs_pkg::*;

  // Command code that the sequencer has no use for.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Tracks the sequencer state and holds the coil and phase values still owed by the block.
  class coil_tracker;
    typedef struct packed {
      logic               coil;
      logic [PHASE_W-1:0] phase;
    } drive_t;

    irs_cfg_t                 regs;
    logic [PHASE_W-1:0]       phase;
    bit                       pending;
    logic signed [TEMP_W-1:0] start_temp;
    logic [BURN_W-1:0]        burn;
    logic [CNT_W-1:0]         pulse;
    bit                       coil;

    drive_t drive_q[$];
    int     mismatches;
    int     checked;
    int     ok_seen;
    int     fail_seen;
    int     coil_seen;

    // Register defaults and cleared state, as after reset.
    function new();
      regs.burn_time_s        = 12'd60;
      regs.pulse_width_ms     = 16'd1000;
      regs.repeat_interval_ms = 16'd10000;
      regs.rise_threshold     = 14'd200;
      phase      = PH_IDLE;
      pending    = 1'b0;
      start_temp = '0;
      burn       = '0;
      pulse      = '0;
      coil       = 1'b0;
      mismatches = 0;
      checked    = 0;
      ok_seen    = 0;
      fail_seen  = 0;
      coil_seen  = 0;
    endfunction

    function int outstanding();
      return drive_q.size();
    endfunction

    // A configuration write keeps only the bits of the register's width.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_BURN_TIME: regs.burn_time_s        = data[SECS_W-1:0];
        REG_PULSE:     regs.pulse_width_ms     = data;
        REG_REPEAT:    regs.repeat_interval_ms = data;
        REG_RISE:      regs.rise_threshold     = data[RISE_W-1:0];
        default: ;
      endcase
    endfunction

    function void energise();
      coil  = 1'b1;
      pulse = regs.pulse_width_ms;
      phase = PH_PULSE;
    endfunction

    // One sequencer step, run after the counters have dropped on a tick.
    function void step_sequencer(logic signed [TEMP_W-1:0] temp);
      longint load;
      case (phase)
        PH_SET: energise();
        PH_PULSE: begin
          if (pulse == '0) begin
            coil  = 1'b0;
            pulse = regs.repeat_interval_ms;
            phase = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (int'(temp) - int'(start_temp) >= int'(regs.rise_threshold))
            phase = PH_OK;
          else if (burn == '0)
            phase = PH_FAIL;
          else if (pulse == '0)
            phase = PH_SET;
        end
        PH_OK, PH_FAIL: ;
        default: begin
          // Idle, and the unreachable codes with it: a pending start begins a run.
          if (pending) begin
            pending    = 1'b0;
            load       = longint'(regs.burn_time_s) * longint'(TICKS_PER_SECOND);
            burn       = (load > longint'(BURN_MAX)) ? BURN_MAX : BURN_W'(load);
            start_temp = temp;
            energise();
          end
        end
      endcase
    endfunction

    // Apply one accepted input transaction and queue the result it must produce.
    function void note_command(logic [CMD_W-1:0] cmd, logic signed [TEMP_W-1:0] temp);
      drive_t d;
      case (cmd)
        CMD_TICK: begin
          if (burn != '0) burn = burn - 1'b1;
          if (pulse != '0) pulse = pulse - 1'b1;
          step_sequencer(temp);
        end
        CMD_START: pending = 1'b1;
        CMD_RESET: begin
          coil  = 1'b0;
          phase = PH_IDLE;
        end
        default: ;
      endcase
      d.coil  = coil;
      d.phase = phase;
      drive_q.push_back(d);
    endfunction

    // Compare one result transaction with the oldest value still owed.
    function void check_drive(logic coil_o, logic [PHASE_W-1:0] phase_o);
      drive_t want;
      if (drive_q.size() == 0) begin
        $error("unexpected result: coil_on %0d phase %0d", coil_o, phase_o);
        mismatches++;
        return;
      end
      want = drive_q.pop_front();
      checked++;
      if (coil_o !== want.coil) begin
        $error("coil_on: expected %0d, actual %0d", want.coil, coil_o);
        mismatches++;
      end
      if (phase_o !== want.phase) begin
        $error("phase: expected %0d, actual %0d", want.phase, phase_o);
        mismatches++;
      end
      if (want.phase == PH_OK) ok_seen++;
      if (want.phase == PH_FAIL) fail_seen++;
      if (want.coil) coil_seen++;
    endfunction
  endclass

endpackage

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import irs_pkg::*;
  import irs_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd = CMD_TICK;
  logic signed [TEMP_W-1:0] in_temperature = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_coil_on;
  logic [PHASE_W-1:0]       out_phase;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_BURN_TIME;
  logic [CFG_DAT_W-1:0]     cfg_data = '0;

  coil_tracker coils = new();
  int          taken_count = 0;
  int          items_sent = 0;
  int          settings_count = 0;
  int          cycle_count = 0;

  ignition_retry_sequencer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_temperature (in_temperature),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_coil_on    (out_coil_on),
    .out_phase      (out_phase),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // A stretch of the run in which neither side idles.
  function automatic bit calm_window();
    return taken_count >= 700 && taken_count < 900;
  endfunction

  function automatic int rand_temp();
    return int'($urandom_range(0, 20479)) - 4096;
  endfunction

  function automatic int clamp_temp(int t);
    if (t < -4096) return -4096;
    if (t > 16383) return 16383;
    return t;
  endfunction

  // Watch every handshake: configuration first, then input, then result.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (cfg_valid && cfg_ready) coils.set_reg(cfg_index, cfg_data);
        if (in_valid && in_ready) begin
          coils.note_command(in_cmd, in_temperature);
          taken_count++;
        end
        if (out_valid && out_ready) coils.check_drive(out_coil_on, out_phase);
      end
    end
  end

  // Result side: random stalls, one long hold-off, and a calm stretch.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && taken_count >= 400) begin
        held = 1'b1;
        hold_left = 300;
        out_ready <= 1'b0;
      end else if (calm_window()) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one input transaction, with a random gap before it, and wait until it is taken.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input int temp);
    while (!calm_window() && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_temperature <= TEMP_W'(temp);
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Stop offering input and wait until every owed result has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (coils.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DAT_W'(data);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic apply_settings(input int unsigned secs, input int unsigned pulse_ms,
                                input int unsigned repeat_ms, input int unsigned rise);
    settle();
    write_reg(REG_BURN_TIME, secs);
    write_reg(REG_PULSE, pulse_ms);
    write_reg(REG_REPEAT, repeat_ms);
    write_reg(REG_RISE, rise);
    settings_count++;
  endtask

  // Mostly whole ignition attempts with a steady or rising temperature, the rest loose noise.
  task automatic run_random(input int quota);
    int stop_at;
    int base;
    int slope;
    int len;
    int unsigned r;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        base  = int'($urandom_range(0, 12000)) - 4096;
        slope = int'($urandom_range(0, 8));
        len   = int'($urandom_range(5, 60));
        if ($urandom_range(3) == 0) send_item(CMD_TICK, rand_temp());
        send_item(CMD_START, rand_temp());
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(99);
          if (r < 3)
            send_item(CMD_START, rand_temp());
          else if (r < 5)
            send_item(CMD_UNUSED, rand_temp());
          else
            send_item(CMD_TICK,
                      clamp_temp(base + k * slope + int'($urandom_range(0, 6)) - 3));
        end
        if ($urandom_range(9) < 8) send_item(CMD_RESET, rand_temp());
      end else begin
        repeat ($urandom_range(1, 8)) send_item(CMD_W'($urandom_range(0, 3)), rand_temp());
      end
    end
  endtask

  // Main sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: idle tick, unused code, starts while idle and busy, reset.
    send_item(CMD_TICK, 0);
    send_item(CMD_UNUSED, 0);
    send_item(CMD_START, 16383);
    send_item(CMD_START, 0);
    send_item(CMD_TICK, -4096);
    send_item(CMD_START, 0);
    send_item(CMD_TICK, 16383);
    send_item(CMD_RESET, 0);
    send_item(CMD_TICK, 0);
    send_item(CMD_RESET, 0);

    // Everything zero: waits end at once, a falling reading fails, an equal one succeeds.
    apply_settings(0, 0, 0, 0);
    send_item(CMD_START, 0);
    send_item(CMD_TICK, 0);
    send_item(CMD_TICK, 0);
    send_item(CMD_TICK, -1);
    send_item(CMD_TICK, 0);
    send_item(CMD_UNUSED, 5);
    send_item(CMD_RESET, 0);
    send_item(CMD_START, 0);
    send_item(CMD_TICK, 100);
    send_item(CMD_TICK, 50);
    send_item(CMD_TICK, 100);
    send_item(CMD_RESET, 0);

    // Random phases over extreme and small settings; each phase overshoots its
    // quota by part of an attempt.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_settings(3600, 65535, 65535, 16383);
        1: apply_settings(1, 65535, 0, 0);
        7: apply_settings(0, 0, 0, 16383);
        default: apply_settings($urandom_range(0, 2), $urandom_range(0, 12),
                                $urandom_range(0, 25), $urandom_range(0, 60));
      endcase
      run_random(140);
    end
    settle();

    $display("Covered %0d input transactions and %0d results over %0d register settings.",
             taken_count, coils.checked, settings_count);
    $display("Results reporting success: %0d, failure: %0d, coil energised: %0d.",
             coils.ok_seen, coils.fail_seen, coils.coil_seen);
    if (coils.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/irs_pkg.sv
hw/rtl/irs_step.sv
hw/rtl/ignition_retry_sequencer.sv
tb/irs_tb_pkg.sv
tb/tb_top.sv
